// ----- hdl/bank_rwa_pkg.sv -----
// Shared types and constants for the bank read/write arbiter.
package bank_rwa_pkg;

   localparam int NUM_BANKS_DEFAULT = 32;
   localparam int QOS_WIDTH_DEFAULT = 4;

   localparam int BANK_SEL_W = 5;
   localparam int QOS_W      = 4;
   localparam int POLICY_W   = 2;
   localparam int BANK_IDX_W = 8;
   localparam int COUNT_W    = 3;

   localparam logic [COUNT_W-1:0] READ_LIMIT = 3'd7;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [POLICY_W-1:0] {
      POLICY_QOS_ALT    = 2'd0,
      POLICY_READ_PRI   = 2'd1,
      POLICY_WRITE_PRI  = 2'd2,
      POLICY_SEVEN_ONE  = 2'd3
   } policy_type;

   // A classified request as it travels from the front to the back.
   typedef struct packed {
      logic                  active;
      logic [BANK_IDX_W-1:0] bank;
      logic                  rd;
      logic                  wr;
      logic                  rd_qos_higher;
      logic                  wr_qos_higher;
   } cmd_type;

endpackage

// ----- hdl/bank_rwa_front.sv -----
// Front stage: accepts requests, checks the bank range and compares QoS levels.
module bank_rwa_front #(
   parameter int NUM_BANKS = bank_rwa_pkg::NUM_BANKS_DEFAULT,
   parameter int QOS_WIDTH = bank_rwa_pkg::QOS_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bank_rwa_pkg::BANK_SEL_W-1:0] req_bank_sel,
   input  logic                                req_read_valid,
   input  logic [bank_rwa_pkg::QOS_W-1:0]      req_read_qos,
   input  logic                                req_write_valid,
   input  logic [bank_rwa_pkg::QOS_W-1:0]      req_write_qos,
   output logic                                cmd_valid,
   input  logic                                cmd_ready,
   output bank_rwa_pkg::cmd_type               cmd
);

   localparam int QOS_KEEP = (QOS_WIDTH < bank_rwa_pkg::QOS_W) ? QOS_WIDTH
                                                                : bank_rwa_pkg::QOS_W;
   localparam logic [bank_rwa_pkg::QOS_W-1:0] QOS_MASK =
      bank_rwa_pkg::QOS_W'((32'd1 << QOS_KEEP) - 32'd1);

   logic                  valid_ff, valid_in;
   bank_rwa_pkg::cmd_type cmd_ff, cmd_in;
   logic                  req_accept;
   logic                  in_range;
   logic [bank_rwa_pkg::QOS_W-1:0] rq, wq;

   assign req_ready  = !valid_ff || cmd_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_range = 9'(req_bank_sel) < 9'(NUM_BANKS);
      rq = req_read_qos & QOS_MASK;
      wq = req_write_qos & QOS_MASK;
      cmd_in.active        = in_range && (req_read_valid || req_write_valid);
      cmd_in.bank          = bank_rwa_pkg::BANK_IDX_W'(req_bank_sel);
      cmd_in.rd            = req_read_valid;
      cmd_in.wr            = req_write_valid;
      cmd_in.rd_qos_higher = rq > wq;
      cmd_in.wr_qos_higher = wq > rq;
   end

   assign valid_in = req_accept || (valid_ff && !cmd_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

// ----- hdl/bank_rwa_queue.sv -----
// Short queue of classified requests between the front and the back.
module bank_rwa_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  bank_rwa_pkg::cmd_type in_cmd,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bank_rwa_pkg::cmd_type out_cmd
);

   localparam int DEPTH = bank_rwa_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bank_rwa_pkg::cmd_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_cmd   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ----- hdl/bank_rwa_back.sv -----
// Back stage: policy register, per-bank state, grant decision and response register.
module bank_rwa_back #(
   parameter int NUM_BANKS = bank_rwa_pkg::NUM_BANKS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [bank_rwa_pkg::POLICY_W-1:0] csr_wr_data,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  bank_rwa_pkg::cmd_type             cmd,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_grant_valid,
   output logic                              rsp_grant_write
);

   localparam int IDX_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

   bank_rwa_pkg::policy_type policy_ff;

   logic                             pref_ff [NUM_BANKS];
   logic [bank_rwa_pkg::COUNT_W-1:0] cnt_ff  [NUM_BANKS];

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             grant_valid_ff, grant_write_ff;
   logic                             pop;
   logic [IDX_W-1:0]                 idx;
   logic                             pref_cur, pref_in, pref_we;
   logic [bank_rwa_pkg::COUNT_W-1:0] cnt_cur, cnt_in;
   logic                             cnt_we;
   logic                             gw;

   assign cmd_ready    = !rsp_valid_ff || rsp_ready;
   assign pop          = cmd_valid && cmd_ready;
   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);

   assign idx      = cmd.bank[IDX_W-1:0];
   assign pref_cur = pref_ff[idx];
   assign cnt_cur  = cnt_ff[idx];

   always_comb begin
      gw      = 1'b0;
      pref_in = pref_cur;
      cnt_in  = cnt_cur;
      pref_we = 1'b0;
      cnt_we  = 1'b0;
      case (policy_ff)
         bank_rwa_pkg::POLICY_QOS_ALT: begin
            if (cmd.rd && cmd.wr) begin
               gw = cmd.wr_qos_higher || (!cmd.rd_qos_higher && pref_cur);
            end else begin
               gw = cmd.wr;
            end
            // Preference moves to the command that lost this round.
            pref_in = !gw;
            pref_we = 1'b1;
         end
         bank_rwa_pkg::POLICY_READ_PRI: begin
            gw = !cmd.rd;
         end
         bank_rwa_pkg::POLICY_WRITE_PRI: begin
            gw = cmd.wr;
         end
         bank_rwa_pkg::POLICY_SEVEN_ONE: begin
            if (cmd.rd && (!cmd.wr || cnt_cur < bank_rwa_pkg::READ_LIMIT)) begin
               gw = 1'b0;
               if (cnt_cur < bank_rwa_pkg::READ_LIMIT) begin
                  cnt_in = cnt_cur + 1'b1;
               end
            end else begin
               gw     = 1'b1;
               cnt_in = '0;
            end
            cnt_we = 1'b1;
         end
         default: begin
            gw = cmd.wr;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= bank_rwa_pkg::POLICY_QOS_ALT;
      end else if (csr_wr_en) begin
         policy_ff <= bank_rwa_pkg::policy_type'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BANKS; i++) begin
            pref_ff[i] <= 1'b0;
            cnt_ff[i]  <= '0;
         end
      end else if (pop && cmd.active) begin
         if (pref_we) begin
            pref_ff[idx] <= pref_in;
         end
         if (cnt_we) begin
            cnt_ff[idx] <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         grant_valid_ff <= cmd.active;
         grant_write_ff <= cmd.active && gw;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_grant_valid = grant_valid_ff;
   assign rsp_grant_write = grant_write_ff;

endmodule

// ----- hdl/bank_read_write_arbiter_core.sv -----
// Top level of the bank read/write arbiter.
// Each request names a sub-bank and the read and write heads waiting there with their QoS
// levels, and gets exactly one response: a grant flag and the granted command (0 read,
// 1 write), or no grant when the sub-bank is out of range or nothing waits. The block takes
// one request per clock and returns one response per clock while the response side does not
// stall. A request passes through the front register, a two-entry queue and the back stage,
// which reads and updates the per-bank preference and read count in the same cycle, so
// requests to one bank may follow each other directly. The policy register is written at any
// edge with csr_wr_en high and must only change while no request is in flight.
module bank_read_write_arbiter_core #(
   parameter int NUM_BANKS = bank_rwa_pkg::NUM_BANKS_DEFAULT,
   parameter int QOS_WIDTH = bank_rwa_pkg::QOS_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [bank_rwa_pkg::POLICY_W-1:0]   csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bank_rwa_pkg::BANK_SEL_W-1:0] req_bank_sel,
   input  logic                                req_read_valid,
   input  logic [bank_rwa_pkg::QOS_W-1:0]      req_read_qos,
   input  logic                                req_write_valid,
   input  logic [bank_rwa_pkg::QOS_W-1:0]      req_write_qos,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_grant_valid,
   output logic                                rsp_grant_write
);

   logic                  front_valid, front_ready;
   bank_rwa_pkg::cmd_type front_cmd;
   logic                  queue_valid, queue_ready;
   bank_rwa_pkg::cmd_type queue_cmd;

   bank_rwa_front #(
      .NUM_BANKS(NUM_BANKS),
      .QOS_WIDTH(QOS_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_bank_sel   (req_bank_sel),
      .req_read_valid (req_read_valid),
      .req_read_qos   (req_read_qos),
      .req_write_valid(req_write_valid),
      .req_write_qos  (req_write_qos),
      .cmd_valid      (front_valid),
      .cmd_ready      (front_ready),
      .cmd            (front_cmd)
   );

   bank_rwa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (front_valid),
      .in_ready (front_ready),
      .in_cmd   (front_cmd),
      .out_valid(queue_valid),
      .out_ready(queue_ready),
      .out_cmd  (queue_cmd)
   );

   bank_rwa_back #(
      .NUM_BANKS(NUM_BANKS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd_valid      (queue_valid),
      .cmd_ready      (queue_ready),
      .cmd            (queue_cmd),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_grant_valid(rsp_grant_valid),
      .rsp_grant_write(rsp_grant_write)
   );

endmodule

// ----- hdl/bank_rwa_checker.sv -----
// Port-level checker for the bank read/write arbiter and its bind statement.
module bank_rwa_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_grant_valid,
   input logic rsp_grant_write
);

   // A stalled response keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_grant_valid)
                                  && $stable(rsp_grant_write))
      else $error("stalled response changed");

   // A write can only be reported as granted.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_grant_valid |-> !rsp_grant_write)
      else $error("write flagged without a grant");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The input side can only back up when a response is waiting.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request refused while no response is pending");

   // Requests are taken after reset without waiting on the response side.
   assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request side not ready after reset");

endmodule

bind bank_read_write_arbiter_core bank_rwa_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_grant_valid(rsp_grant_valid),
   .rsp_grant_write(rsp_grant_write)
);
